/* src/owbm_pkg.sv */
package owbm_pkg;

  // Field and register widths.
  localparam int unsigned REQ_W        = 3;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned LONG_W       = 10;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 10;
  localparam int unsigned TIMER_BITS_DEF = 10;

  // Request codes carried by an input beat.
  localparam logic [REQ_W-1:0] REQ_TICK     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_RESET    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PRESENCE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_WRITE    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ     = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_REC    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GAP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DELAY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_TAIL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_HIGH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_LOW     = 3'd7;

  // Configuration reset values.
  localparam logic [LONG_W-1:0] DEF_RESET_LOW    = 10'd750;
  localparam logic [BYTE_W-1:0] DEF_RESET_REC    = 8'd15;
  localparam logic [BYTE_W-1:0] DEF_SHORT_GAP    = 8'd2;
  localparam logic [BYTE_W-1:0] DEF_SLOT         = 8'd60;
  localparam logic [BYTE_W-1:0] DEF_SAMPLE_DELAY = 8'd5;
  localparam logic [BYTE_W-1:0] DEF_READ_TAIL    = 8'd55;
  localparam logic [LONG_W-1:0] DEF_PRES_HIGH    = 10'd200;
  localparam logic [LONG_W-1:0] DEF_PRES_LOW     = 10'd240;

  // Reflected CRC-8 polynomial.
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

  // Bus sequencer phases.
  typedef enum logic [12:0] {
    PH_IDLE      = 13'b0000000000001,
    PH_RST_LOW   = 13'b0000000000010,
    PH_RST_REC   = 13'b0000000000100,
    PH_PRES_HIGH = 13'b0000000001000,
    PH_PRES_LOW  = 13'b0000000010000,
    PH_WR_LOW    = 13'b0000000100000,
    PH_WR_HIGH   = 13'b0000001000000,
    PH_RD_LOW    = 13'b0000010000000,
    PH_RD_WAIT   = 13'b0000100000000,
    PH_RD_SAMPLE = 13'b0001000000000,
    PH_RD_TAIL   = 13'b0010000000000,
    PH_RD_GAP    = 13'b0100000000000,
    PH_RD_END    = 13'b1000000000000
  } phase_t;

  // Folds one byte, LSB first, into a reflected CRC-8.
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data_in);
    logic [BYTE_W-1:0] crc;
    logic [BYTE_W-1:0] dat;
    logic              mix;
    crc = crc_in;
    dat = data_in;
    for (int i = 0; i < BYTE_W; i++) begin
      mix = crc[0] ^ dat[0];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CRC_POLY;
      end
      dat = dat >> 1;
    end
    return crc;
  endfunction

endpackage

/* src/one_wire_bus_master_unit.sv */
// 1-Wire bus master, stepped by one input beat per bus microsecond.
// Input channel (in_*): each beat carries the sampled line level and, while
// the master is idle, an optional command: reset pulse, presence check, byte
// write or byte read. Commands given while busy are ignored.
// Result channel (out_*): exactly one beat per input beat, with the level to
// drive, busy, done, presence status, last read byte and the running CRC-8.
// Configuration channel (cfg_*): register index and data; always ready and
// meant to be written only while no command is running.
// A beat taken sits in the input register, is worked through the sequencer
// logic and lands in the result register once that register is free or its
// beat is taken; a stall of the receiver can hold it in the input register.
// Throughput: one beat per cycle while the receiver does not stall, set by
// the sequencer update between the input register and the result register.
// Reset: rst_n low returns the timings to their defaults, the sequencer to
// idle with the line released, and clears CRC, last byte and status.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more beat; after that in_ready drops.
module one_wire_bus_master_unit #(
  parameter int unsigned TIMER_BITS = owbm_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [owbm_pkg::REQ_W-1:0]      in_req_type,
  input  logic [owbm_pkg::BYTE_W-1:0]     in_write_data,
  input  logic                            in_line_in,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_line_out,
  output logic                            out_busy_res,
  output logic                            out_done_res,
  output logic                            out_status,
  output logic [owbm_pkg::BYTE_W-1:0]     out_read_byte_out,
  output logic [owbm_pkg::BYTE_W-1:0]     out_crc_out,
  // Configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [owbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [owbm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import owbm_pkg::*;

  localparam int unsigned CMP_W = (TIMER_BITS > LONG_W) ? TIMER_BITS : LONG_W;
  localparam logic [TIMER_BITS-1:0] TMR_MAX = {TIMER_BITS{1'b1}};
  localparam logic [TIMER_BITS-1:0] TMR_ONE = TIMER_BITS'(1);

  // Clamps a duration to at least one tick and at most the timer range.
  function automatic logic [TIMER_BITS-1:0] sat_dur(input logic [LONG_W-1:0] dur);
    logic [CMP_W-1:0] dx;
    dx = CMP_W'(dur);
    if (dur == '0) begin
      return TMR_ONE;
    end
    if (dx > CMP_W'(TMR_MAX)) begin
      return TMR_MAX;
    end
    return TIMER_BITS'(dx);
  endfunction

  // Configuration registers
  logic [LONG_W-1:0] reset_low_r;
  logic [BYTE_W-1:0] reset_rec_r;
  logic [BYTE_W-1:0] short_gap_r;
  logic [BYTE_W-1:0] slot_r;
  logic [BYTE_W-1:0] sample_delay_r;
  logic [BYTE_W-1:0] read_tail_r;
  logic [LONG_W-1:0] pres_high_r;
  logic [LONG_W-1:0] pres_low_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_low_r    <= DEF_RESET_LOW;
      reset_rec_r    <= DEF_RESET_REC;
      short_gap_r    <= DEF_SHORT_GAP;
      slot_r         <= DEF_SLOT;
      sample_delay_r <= DEF_SAMPLE_DELAY;
      read_tail_r    <= DEF_READ_TAIL;
      pres_high_r    <= DEF_PRES_HIGH;
      pres_low_r     <= DEF_PRES_LOW;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RESET_LOW:    reset_low_r    <= cfg_data;
        CFG_RESET_REC:    reset_rec_r    <= cfg_data[BYTE_W-1:0];
        CFG_SHORT_GAP:    short_gap_r    <= cfg_data[BYTE_W-1:0];
        CFG_SLOT:         slot_r         <= cfg_data[BYTE_W-1:0];
        CFG_SAMPLE_DELAY: sample_delay_r <= cfg_data[BYTE_W-1:0];
        CFG_READ_TAIL:    read_tail_r    <= cfg_data[BYTE_W-1:0];
        CFG_PRES_HIGH:    pres_high_r    <= cfg_data;
        CFG_PRES_LOW:     pres_low_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register stage
  logic              s1_valid_r;
  logic [REQ_W-1:0]  s1_req_r;
  logic [BYTE_W-1:0] s1_wdata_r;
  logic              s1_line_r;
  logic              s1_fire;

  assign s1_fire  = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_r   <= in_req_type;
      s1_wdata_r <= in_write_data;
      s1_line_r  <= in_line_in;
    end
  end

  // Sequencer state
  phase_t                phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic [2:0]            bit_cnt_r, bit_cnt_nxt;
  logic [BYTE_W-1:0]     shift_r, shift_nxt;
  logic                  drive_r, drive_nxt;
  logic [BYTE_W-1:0]     crc_r, crc_nxt;
  logic [BYTE_W-1:0]     last_rd_r, last_rd_nxt;
  logic                  pfail_r, pfail_nxt;
  logic                  done_nxt;
  logic                  busy_nxt;
  logic                  level_nxt;

  // One tick of the bus sequencer: command start, then the phase step.
  always_comb begin
    phase_nxt   = phase_r;
    timer_nxt   = timer_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    drive_nxt   = drive_r;
    crc_nxt     = crc_r;
    last_rd_nxt = last_rd_r;
    pfail_nxt   = pfail_r;
    done_nxt    = 1'b0;
    busy_nxt    = 1'b0;
    level_nxt   = 1'b1;

    // A command on an idle tick starts on that same tick.
    if (phase_r == PH_IDLE) begin
      case (s1_req_r)
        REQ_RESET: begin
          crc_nxt   = '0;
          phase_nxt = PH_RST_LOW;
          timer_nxt = sat_dur(reset_low_r);
          drive_nxt = 1'b0;
        end
        REQ_PRESENCE: begin
          phase_nxt = PH_PRES_HIGH;
          timer_nxt = '0;
          drive_nxt = 1'b1;
        end
        REQ_WRITE: begin
          shift_nxt   = s1_wdata_r;
          bit_cnt_nxt = '0;
          phase_nxt   = PH_WR_LOW;
          timer_nxt   = sat_dur(LONG_W'(s1_wdata_r[0] ? short_gap_r : slot_r));
          drive_nxt   = 1'b0;
        end
        REQ_READ: begin
          shift_nxt   = '0;
          bit_cnt_nxt = '0;
          phase_nxt   = PH_RD_LOW;
          timer_nxt   = sat_dur(LONG_W'(short_gap_r));
          drive_nxt   = 1'b0;
        end
        default: ;
      endcase
    end

    if (phase_nxt != PH_IDLE) begin
      busy_nxt  = 1'b1;
      level_nxt = drive_nxt;
      case (phase_nxt)
        // Wait for the line to go low, with a timeout on high ticks.
        PH_PRES_HIGH: begin
          if (s1_line_r) begin
            timer_nxt = timer_nxt + TMR_ONE;
            if (CMP_W'(timer_nxt) >= CMP_W'(pres_high_r)) begin
              pfail_nxt = 1'b1;
              phase_nxt = PH_IDLE;
              timer_nxt = '0;
              drive_nxt = 1'b1;
              done_nxt  = 1'b1;
            end
          end else begin
            timer_nxt = TMR_ONE;
            if (CMP_W'(TMR_ONE) >= CMP_W'(pres_low_r)) begin
              pfail_nxt = 1'b1;
              phase_nxt = PH_IDLE;
              timer_nxt = '0;
              drive_nxt = 1'b1;
              done_nxt  = 1'b1;
            end else begin
              phase_nxt = PH_PRES_LOW;
            end
          end
        end
        // Wait for the line to come back high, with a timeout on low ticks.
        PH_PRES_LOW: begin
          if (s1_line_r) begin
            pfail_nxt = 1'b0;
            phase_nxt = PH_IDLE;
            timer_nxt = '0;
            drive_nxt = 1'b1;
            done_nxt  = 1'b1;
          end else begin
            timer_nxt = timer_nxt + TMR_ONE;
            if (CMP_W'(timer_nxt) >= CMP_W'(pres_low_r)) begin
              pfail_nxt = 1'b1;
              phase_nxt = PH_IDLE;
              timer_nxt = '0;
              drive_nxt = 1'b1;
              done_nxt  = 1'b1;
            end
          end
        end
        // Sample the line into the top of the shift register.
        PH_RD_SAMPLE: begin
          shift_nxt = {s1_line_r, shift_nxt[BYTE_W-1:1]};
          drive_nxt = 1'b1;
          if (read_tail_r <= 8'd1) begin
            phase_nxt = PH_RD_GAP;
            timer_nxt = sat_dur(LONG_W'(short_gap_r));
          end else begin
            phase_nxt = PH_RD_TAIL;
            timer_nxt = sat_dur(LONG_W'(read_tail_r - 8'd1));
          end
        end
        // Timed phases count down and move on when the count runs out.
        default: begin
          if (timer_nxt <= TMR_ONE) begin
            case (phase_nxt)
              PH_RST_LOW: begin
                phase_nxt = PH_RST_REC;
                timer_nxt = sat_dur(LONG_W'(reset_rec_r));
                drive_nxt = 1'b1;
              end
              PH_WR_LOW: begin
                phase_nxt = PH_WR_HIGH;
                timer_nxt = sat_dur(LONG_W'(shift_nxt[0] ? slot_r : short_gap_r));
                drive_nxt = 1'b1;
              end
              PH_WR_HIGH: begin
                if (bit_cnt_nxt == 3'd7) begin
                  phase_nxt = PH_IDLE;
                  timer_nxt = '0;
                  drive_nxt = 1'b1;
                  done_nxt  = 1'b1;
                end else begin
                  bit_cnt_nxt = bit_cnt_nxt + 3'd1;
                  shift_nxt   = shift_nxt >> 1;
                  phase_nxt   = PH_WR_LOW;
                  timer_nxt   = sat_dur(LONG_W'(shift_nxt[0] ? short_gap_r : slot_r));
                  drive_nxt   = 1'b0;
                end
              end
              PH_RD_LOW: begin
                phase_nxt = PH_RD_WAIT;
                timer_nxt = sat_dur(LONG_W'(sample_delay_r));
                drive_nxt = 1'b1;
              end
              PH_RD_WAIT: begin
                phase_nxt = PH_RD_SAMPLE;
                timer_nxt = '0;
                drive_nxt = 1'b1;
              end
              PH_RD_TAIL: begin
                phase_nxt = PH_RD_GAP;
                timer_nxt = sat_dur(LONG_W'(short_gap_r));
                drive_nxt = 1'b1;
              end
              PH_RD_GAP: begin
                if (bit_cnt_nxt == 3'd7) begin
                  phase_nxt = PH_RD_END;
                  drive_nxt = 1'b1;
                end else begin
                  bit_cnt_nxt = bit_cnt_nxt + 3'd1;
                  phase_nxt   = PH_RD_LOW;
                  drive_nxt   = 1'b0;
                end
                timer_nxt = sat_dur(LONG_W'(short_gap_r));
              end
              PH_RD_END: begin
                last_rd_nxt = shift_nxt;
                crc_nxt     = crc8_byte(crc_nxt, shift_nxt);
                phase_nxt   = PH_IDLE;
                timer_nxt   = '0;
                drive_nxt   = 1'b1;
                done_nxt    = 1'b1;
              end
              default: begin
                phase_nxt = PH_IDLE;
                timer_nxt = '0;
                drive_nxt = 1'b1;
                done_nxt  = 1'b1;
              end
            endcase
          end else begin
            timer_nxt = timer_nxt - TMR_ONE;
          end
        end
      endcase
    end
  end

  // State update, one tick per beat that leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      timer_r   <= '0;
      bit_cnt_r <= '0;
      shift_r   <= '0;
      drive_r   <= 1'b1;
      crc_r     <= '0;
      last_rd_r <= '0;
      pfail_r   <= 1'b0;
    end else if (s1_fire) begin
      phase_r   <= phase_nxt;
      timer_r   <= timer_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      drive_r   <= drive_nxt;
      crc_r     <= crc_nxt;
      last_rd_r <= last_rd_nxt;
      pfail_r   <= pfail_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_line_out      <= level_nxt;
      out_busy_res      <= busy_nxt;
      out_done_res      <= done_nxt;
      out_status        <= pfail_nxt;
      out_read_byte_out <= last_rd_nxt;
      out_crc_out       <= crc_nxt;
    end
  end

  // The sequencer never advances while a result is stuck in the output.
  a_no_step_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !s1_fire)
    else $error("sequencer stepped while the result register was stalled");

  // Every beat taken by the sequencer produces a result beat.
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid)
    else $error("sequencer step produced no result beat");

  // The line is only pulled low by a running command.
  a_low_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_line_out) |-> out_busy_res)
    else $error("line driven low while no command was running");

  // An idle sequencer has the line released and its timer cleared.
  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (drive_r && (timer_r == '0)))
    else $error("idle sequencer holds the line or a running timer");

  // A completed command is reported on a busy tick.
  a_done_is_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> out_busy_res)
    else $error("done reported outside a command");

endmodule
